FILE: rtl/gamepad_input_conditioner_macros.svh
// Assertion macros for the gamepad input conditioner checker.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef GAMEPAD_INPUT_CONDITIONER_MACROS_SVH
`define GAMEPAD_INPUT_CONDITIONER_MACROS_SVH

// Same-cycle implication, off while in reset
`define GIC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define GIC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is seen
`define GIC_ASSERT_AFTER_RESET(name, cons, msg) \
  name: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gic_pkg.sv
// Shared types and constants of the gamepad input conditioner.
// No dependencies.
package gic_pkg;

  // Q1.14 full scale
  localparam int Q_ONE = 16384;

  // Button bit positions in the button word
  localparam int BTN_UP     = 2;
  localparam int BTN_RIGHT  = 3;
  localparam int BTN_DOWN   = 4;
  localparam int BTN_LEFT   = 5;
  localparam int BTN_LTRIG  = 6;
  localparam int BTN_RTRIG  = 7;
  localparam int BTN_CIRCLE = 9;

  // Step / direction codes
  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_POS  = 2'sb01;
  localparam logic signed [1:0] STEP_NEG  = 2'sb11;

  // Rear pan: round(x*16384/960) = floor((x*256 + 7) / 15), reciprocal 2^24/15
  localparam logic [20:0] PAN_RECIP = 21'd1118482;
  localparam logic [22:0] PAN_BIAS  = 23'd7829374;      // 7 * PAN_RECIP
  localparam int          PAN_SHIFT = 24;

  // Rear tilt: round(y*16384/445) = floor((y*16384 + 222) / 445), reciprocal 2^33/445
  localparam logic [24:0] TILT_RECIP = 25'd19303224;
  localparam logic [32:0] TILT_BIAS  = 33'd4285315728;  // 222 * TILT_RECIP
  localparam int          TILT_SHIFT = 33;

  typedef logic signed [15:0] q14_t;

  // Button and touch results of one sample
  typedef struct packed {
    logic [11:0]       pressed_mask;
    logic signed [1:0] lifter;
    logic              estop;
    logic signed [1:0] speed_step;
    logic signed [1:0] robot_step;
    logic [9:0]        touch_x;
    logic [9:0]        touch_y;
    logic              touch_active;
  } ev_t;

endpackage

FILE: rtl/gamepad_input_conditioner.sv
// Gamepad input conditioner: one controller sample in, one conditioned result out.
// The result register takes each result from the input register; a result stall holds both.
// Throughput: one request per cycle unless stalled; rear-touch multipliers set the path.
// Reset (rst, synchronous): empties both registers, clears edge history, e-stop and held touch.
// Depends on gic_pkg, gic_axis, gic_rear, gic_events.
module gamepad_input_conditioner import gic_pkg::*; #(
  parameter int DEAD_ZONE = 24
) (
  input  logic               clk,
  input  logic               rst,
  // Request channel
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic [7:0]         left_x,
  input  logic [7:0]         left_y,
  input  logic [7:0]         right_x,
  input  logic [7:0]         right_y,
  input  logic [11:0]        button_bits,
  input  logic               rear_present,
  input  logic [10:0]        rear_x,
  input  logic [9:0]         rear_y,
  input  logic               front_present,
  input  logic [10:0]        front_x,
  input  logic [10:0]        front_y,
  // Result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [15:0] linear,
  output logic signed [15:0] angular,
  output logic signed [15:0] cam_pan,
  output logic signed [15:0] camera_tilt,
  output logic signed [1:0]  lifter,
  output logic               estop,
  output logic signed [1:0]  speed_step,
  output logic signed [1:0]  robot_step,
  output logic [11:0]        pressed_mask,
  output logic [9:0]         touch_x,
  output logic [9:0]         touch_y,
  output logic               touch_active
);

  // Input register
  logic        stage_valid;
  logic [7:0]  s_left_x, s_left_y, s_right_x, s_right_y;
  logic [11:0] s_buttons;
  logic        s_rear_present;
  logic [10:0] s_rear_x;
  logic [9:0]  s_rear_y;
  logic        s_front_present;
  logic [10:0] s_front_x;
  logic [10:0] s_front_y;

  logic adv_out;
  logic adv_in;
  logic move;

  q14_t ax_lx, ax_ly, ax_rx, ax_ry;
  q14_t lin_next, stilt, rpan, rtilt;
  q14_t pan_next, tilt_next;
  ev_t  ev;

  // Flow control
  assign adv_out      = !result_valid || !result_stall;
  assign adv_in       = !stage_valid || adv_out;
  assign sample_stall = !adv_in;
  assign move         = stage_valid && adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (adv_in) begin
      stage_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && adv_in) begin
      s_left_x        <= left_x;
      s_left_y        <= left_y;
      s_right_x       <= right_x;
      s_right_y       <= right_y;
      s_buttons       <= button_bits;
      s_rear_present  <= rear_present;
      s_rear_x        <= rear_x;
      s_rear_y        <= rear_y;
      s_front_present <= front_present;
      s_front_x       <= front_x;
      s_front_y       <= front_y;
    end
  end

  // Stick axes
  gic_axis #(.DEAD_ZONE(DEAD_ZONE)) u_axis_lx (.raw(s_left_x),  .q(ax_lx));
  gic_axis #(.DEAD_ZONE(DEAD_ZONE)) u_axis_ly (.raw(s_left_y),  .q(ax_ly));
  gic_axis #(.DEAD_ZONE(DEAD_ZONE)) u_axis_rx (.raw(s_right_x), .q(ax_rx));
  gic_axis #(.DEAD_ZONE(DEAD_ZONE)) u_axis_ry (.raw(s_right_y), .q(ax_ry));

  // Rear touch fallback
  gic_rear u_rear (
    .present (s_rear_present),
    .rx      (s_rear_x),
    .ry      (s_rear_y),
    .pan     (rpan),
    .tilt    (rtilt)
  );

  // Buttons and front touch
  gic_events u_events (
    .clk           (clk),
    .rst           (rst),
    .adv           (move),
    .button_bits   (s_buttons),
    .front_present (s_front_present),
    .front_x       (s_front_x),
    .front_y       (s_front_y),
    .ev            (ev)
  );

  // Y axes are negated; stick wins over rear touch when nonzero
  assign lin_next  = -ax_ly;
  assign stilt     = -ax_ry;
  assign pan_next  = (ax_rx != '0) ? ax_rx : rpan;
  assign tilt_next = (stilt != '0) ? stilt : rtilt;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv_out) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      linear       <= lin_next;
      angular      <= ax_lx;
      cam_pan      <= pan_next;
      camera_tilt  <= tilt_next;
      lifter       <= ev.lifter;
      estop        <= ev.estop;
      speed_step   <= ev.speed_step;
      robot_step   <= ev.robot_step;
      pressed_mask <= ev.pressed_mask;
      touch_x      <= ev.touch_x;
      touch_y      <= ev.touch_y;
      touch_active <= ev.touch_active;
    end
  end

endmodule

FILE: rtl/gic_axis.sv
// One stick axis: centering, deadzone, rescale to Q1.14 through a constant table.
// Depends on gic_pkg.
module gic_axis import gic_pkg::*; #(
  parameter int DEAD_ZONE = 24
) (
  input  logic [7:0] raw,
  output q14_t       q
);

  localparam int unsigned Div = 128 - DEAD_ZONE;
  localparam logic [7:0]  Dz  = 8'(DEAD_ZONE);

  logic [14:0]       tbl [256];
  logic signed [8:0] v;
  logic [7:0]        mag_raw;
  logic [7:0]        mag;
  logic              in_zone;
  logic [14:0]       qmag;

  // Rounded magnitude table: round(m * 16384 / Div), clamped to one
  for (genvar i = 0; i < 256; i++) begin : g_tbl
    localparam int unsigned Raw = (i * 32768 + Div) / (2 * Div);
    localparam int unsigned Cl  = (Raw > Q_ONE) ? Q_ONE : Raw;
    assign tbl[i] = 15'(Cl);
  end

  // Center and fold to magnitude
  assign v       = $signed({1'b0, raw}) - 9'sd128;
  assign mag_raw = v[8] ? 8'(-v) : v[7:0];
  assign in_zone = mag_raw < Dz;
  assign mag     = mag_raw - Dz;
  assign qmag    = tbl[mag];

  // Restore sign
  always_comb begin
    if (in_zone) begin
      q = '0;
    end else if (v[8]) begin
      q = -$signed({1'b0, qmag});
    end else begin
      q = $signed({1'b0, qmag});
    end
  end

endmodule

FILE: rtl/gic_rear.sv
// Rear touch point to camera pan and tilt in Q1.14, by reciprocal multiplication.
// Depends on gic_pkg.
module gic_rear import gic_pkg::*; (
  input  logic        present,
  input  logic [10:0] rx,
  input  logic [9:0]  ry,
  output q14_t        pan,
  output q14_t        tilt
);

  logic [31:0]        pan_mul;
  logic [39:0]        pan_sum;
  logic [15:0]        px;
  logic [34:0]        tilt_mul;
  logic [48:0]        tilt_sum;
  logic [15:0]        ty;
  logic signed [17:0] pan_d;
  logic signed [17:0] tilt_d;

  function automatic q14_t sat_q14(input logic signed [17:0] val);
    if (val > 18'sd16384) begin
      return 16'sd16384;
    end else if (val < -18'sd16384) begin
      return -16'sd16384;
    end
    return val[15:0];
  endfunction

  // Pan: floor((x*256 + 7) / 15)
  assign pan_mul = 32'(rx) * 32'(PAN_RECIP);
  assign pan_sum = {pan_mul, 8'b0} + 40'(PAN_BIAS);
  assign px      = pan_sum[PAN_SHIFT +: 16];

  // Tilt: floor((y*16384 + 222) / 445)
  assign tilt_mul = 35'(ry) * 35'(TILT_RECIP);
  assign tilt_sum = {tilt_mul, 14'b0} + 49'(TILT_BIAS);
  assign ty       = tilt_sum[TILT_SHIFT +: 16];

  // Offset by one (tilt inverted) and saturate
  assign pan_d  = $signed({2'b0, px}) - 18'sd16384;
  assign tilt_d = 18'sd16384 - $signed({2'b0, ty});

  assign pan  = present ? sat_q14(pan_d) : '0;
  assign tilt = present ? sat_q14(tilt_d) : '0;

endmodule

FILE: rtl/gic_events.sv
// Button edge detection, trigger lifter code, e-stop latch, d-pad steps and held front touch point.
// Depends on gic_pkg. State advances when adv is high.
module gic_events import gic_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic [11:0] button_bits,
  input  logic        front_present,
  input  logic [10:0] front_x,
  input  logic [10:0] front_y,
  output ev_t         ev
);

  logic [11:0] btn_last;
  logic        estop_latch;
  logic [9:0]  held_touch_x;
  logic [9:0]  held_touch_y;
  logic [11:0] pressed;

  assign pressed = button_bits & ~btn_last;

  // Results of this sample, including state after it
  always_comb begin
    ev.pressed_mask = pressed;

    ev.lifter = STEP_NONE;
    if (button_bits[BTN_RTRIG]) begin
      ev.lifter = STEP_POS;
    end else if (button_bits[BTN_LTRIG]) begin
      ev.lifter = STEP_NEG;
    end

    ev.estop = estop_latch ^ pressed[BTN_CIRCLE];

    ev.speed_step = STEP_NONE;
    if (pressed[BTN_DOWN]) begin
      ev.speed_step = STEP_NEG;
    end else if (pressed[BTN_UP]) begin
      ev.speed_step = STEP_POS;
    end

    ev.robot_step = STEP_NONE;
    if (pressed[BTN_LEFT]) begin
      ev.robot_step = STEP_NEG;
    end else if (pressed[BTN_RIGHT]) begin
      ev.robot_step = STEP_POS;
    end

    if (front_present) begin
      ev.touch_x = front_x[10:1];
      ev.touch_y = front_y[10:1];
    end else begin
      ev.touch_x = held_touch_x;
      ev.touch_y = held_touch_y;
    end
    ev.touch_active = front_present;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      btn_last     <= '0;
      estop_latch  <= 1'b0;
      held_touch_x <= '0;
      held_touch_y <= '0;
    end else if (adv) begin
      btn_last     <= button_bits;
      estop_latch  <= ev.estop;
      held_touch_x <= ev.touch_x;
      held_touch_y <= ev.touch_y;
    end
  end

endmodule

FILE: rtl/gic_checker.sv
// Port-level checker for the gamepad input conditioner, bound to the top level.
// Depends on gic_pkg and gamepad_input_conditioner_macros.svh.
`include "gamepad_input_conditioner_macros.svh"

module gic_checker import gic_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               sample_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [15:0] linear,
  input logic signed [15:0] angular,
  input logic signed [15:0] cam_pan,
  input logic signed [15:0] camera_tilt,
  input logic signed [1:0]  lifter,
  input logic signed [1:0]  speed_step,
  input logic signed [1:0]  robot_step
);

  logic        stalled;
  logic [69:0] res_word;
  logic        axes_ok;
  logic        steps_ok;

  function automatic logic in_q14(input logic signed [15:0] val);
    return (val >= -16'sd16384) && (val <= 16'sd16384);
  endfunction

  assign stalled  = result_valid && result_stall;
  assign res_word = {linear, angular, cam_pan, camera_tilt, lifter, speed_step, robot_step};
  assign axes_ok  = in_q14(linear) && in_q14(angular) && in_q14(cam_pan) &&
                    in_q14(camera_tilt);
  assign steps_ok = (lifter inside {STEP_NONE, STEP_POS, STEP_NEG}) &&
                    (speed_step inside {STEP_NONE, STEP_POS, STEP_NEG}) &&
                    (robot_step inside {STEP_NONE, STEP_POS, STEP_NEG});

  // Stalled result keeps its payload
  `GIC_ASSERT_NEXT(a_result_hold, stalled, result_valid && $stable(res_word), "stall moved data")

  // Analog outputs stay within plus or minus one
  `GIC_ASSERT_NOW(a_q14_range, result_valid, axes_ok, "axis result out of range")

  // Step codes never take the unused value
  `GIC_ASSERT_NOW(a_step_codes, result_valid, steps_ok, "illegal step code")

  // Pipeline is empty after reset
  `GIC_ASSERT_AFTER_RESET(a_reset_empty, !result_valid && !sample_stall, "not empty after reset")

endmodule

bind gamepad_input_conditioner gic_checker u_gic_checker (.*);
